### rtl/core/aes_cbc_pkg.sv
// Shared types, constants and round functions for the AES-CBC block cipher.
package aes_cbc_pkg;

    localparam int RK_DEPTH = 60;
    localparam int RK_WIDTH = 32;
    localparam int RK_AW    = 6;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ENCRYPT = 2'd1,
        CMD_DECRYPT = 2'd2,
        CMD_RSVD    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_KEY_SIZE = 3'd0,
        REG_KEY_A    = 3'd1,
        REG_KEY_B    = 3'd2,
        REG_KEY_C    = 3'd3,
        REG_KEY_D    = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EXPAND,
        ST_FETCH,
        ST_ROUND,
        ST_DONE
    } t_state;

    // Round-key write port from the key scheduler.
    typedef struct packed {
        logic                en;
        logic [RK_AW-1:0]    addr;
        logic [RK_WIDTH-1:0] data;
    } t_rk_wr;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ks_stat;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = 8'h01;
            4'd1: r = 8'h02;
            4'd2: r = 8'h04;
            4'd3: r = 8'h08;
            4'd4: r = 8'h10;
            4'd5: r = 8'h20;
            4'd6: r = 8'h40;
            4'd7: r = 8'h80;
            4'd8: r = 8'h1b;
            4'd9: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Forward round without key add: SubBytes, ShiftRows, optional MixColumns.
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = sbox(b[4*((c+r)%4)+r]);
        for (int c = 0; c < 4; c++) begin
            if (mix) begin
                o[127-8*(4*c)   -: 8] = xt(t[4*c]) ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2]
                                        ^ t[4*c+3];
                o[127-8*(4*c+1) -: 8] = t[4*c] ^ xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2]
                                        ^ t[4*c+3];
                o[127-8*(4*c+2) -: 8] = t[4*c] ^ t[4*c+1] ^ xt(t[4*c+2]) ^ xt(t[4*c+3])
                                        ^ t[4*c+3];
                o[127-8*(4*c+3) -: 8] = xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2]
                                        ^ xt(t[4*c+3]);
            end else begin
                for (int r = 0; r < 4; r++) o[127-8*(4*c+r) -: 8] = t[4*c+r];
            end
        end
        return o;
    endfunction

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] k);
        logic [7:0] a2, a4, a8, p;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        p  = (k[0] ? a : 8'h00) ^ (k[1] ? a2 : 8'h00) ^ (k[2] ? a4 : 8'h00)
             ^ (k[3] ? a8 : 8'h00);
        return p;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] a [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) a[i] = s[127-8*i -: 8];
        for (int c = 0; c < 4; c++) begin
            o[127-8*(4*c)   -: 8] = gm(a[4*c],4'he) ^ gm(a[4*c+1],4'hb) ^ gm(a[4*c+2],4'hd)
                                    ^ gm(a[4*c+3],4'h9);
            o[127-8*(4*c+1) -: 8] = gm(a[4*c],4'h9) ^ gm(a[4*c+1],4'he) ^ gm(a[4*c+2],4'hb)
                                    ^ gm(a[4*c+3],4'hd);
            o[127-8*(4*c+2) -: 8] = gm(a[4*c],4'hd) ^ gm(a[4*c+1],4'h9) ^ gm(a[4*c+2],4'he)
                                    ^ gm(a[4*c+3],4'hb);
            o[127-8*(4*c+3) -: 8] = gm(a[4*c],4'hb) ^ gm(a[4*c+1],4'hd) ^ gm(a[4*c+2],4'h9)
                                    ^ gm(a[4*c+3],4'he);
        end
        return o;
    endfunction

    // Inverse ShiftRows and InvSubBytes.
    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [7:0] b [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127-8*(4*((c+r)%4)+r) -: 8] = inv_sbox(b[4*c+r]);
        return o;
    endfunction

endpackage

### rtl/core/aes_cbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module aes_cbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/aes_cbc_keysched.sv
// Key expansion: writes one round-key word a cycle into the round-key store.
module aes_cbc_keysched (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [1:0]                     i_key_size_mode,
    input  logic [255:0]                   i_key,
    output aes_cbc_pkg::t_rk_wr            o_wr,
    output aes_cbc_pkg::t_ks_stat          o_stat
);
    // Sliding window of the last eight words; word i-1 in slot 0.
    logic [31:0] r_win [8];
    logic [31:0] n_win [8];
    logic [5:0]  r_idx, n_idx;
    logic [3:0]  r_nk,  n_nk;
    logic [5:0]  r_total, n_total;
    logic [3:0]  r_phase, n_phase;  // i mod nk
    logic [3:0]  r_rc, n_rc;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [31:0] w_new;
    logic [31:0] w_t;
    logic [31:0] w_prev_nk;

    always_comb begin
        w_prev_nk = r_win[3'(r_nk - 4'd1)];
        w_t = r_win[0];
        if (r_phase == 4'd0) begin
            w_t = aes_cbc_pkg::sub_word({r_win[0][23:0], r_win[0][31:24]})
                  ^ {aes_cbc_pkg::rcon(r_rc), 24'h0};
        end else if (r_nk == 4'd8 && r_phase == 4'd4) begin
            w_t = aes_cbc_pkg::sub_word(r_win[0]);
        end
        w_new = (r_idx < 6'(r_nk)) ? i_key[255 - 32*r_idx -: 32] : (w_prev_nk ^ w_t);
    end

    always_comb begin
        logic [1:0] m;
        n_win = r_win;
        n_idx = r_idx;
        n_nk = r_nk;
        n_total = r_total;
        n_phase = r_phase;
        n_rc = r_rc;
        n_busy = r_busy;
        n_done = 1'b0;
        m = (i_key_size_mode == 2'd3) ? 2'd2 : i_key_size_mode;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx = '0;
            n_nk = 4'd4 + {1'b0, m, 1'b0};
            n_total = 6'd44 + {1'b0, m, 3'b000};
            n_phase = '0;
            n_rc = '0;
        end else if (r_busy) begin
            for (int k = 7; k > 0; k--) n_win[k] = r_win[k-1];
            n_win[0] = w_new;
            n_idx = r_idx + 6'd1;
            if (r_phase == r_nk - 4'd1) begin
                n_phase = '0;
                if (r_idx >= 6'(r_nk)) n_rc = r_rc + 4'd1;
            end else begin
                n_phase = r_phase + 4'd1;
            end
            if (r_idx == r_total - 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_win   <= n_win;
        r_idx   <= n_idx;
        r_nk    <= n_nk;
        r_total <= n_total;
        r_phase <= n_phase;
        r_rc    <= n_rc;
    end

    assign o_wr.en   = r_busy && !i_start;
    assign o_wr.addr = r_idx;
    assign o_wr.data = w_new;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

### rtl/core/aes_cbc_block_cipher.sv
// Top level of the AES-CBC block cipher with round-key memory and round engine.
//
// AES-128/192/256 in CBC mode. Configuration writes set the key size and key
// bytes; each write to one of these restarts key expansion, which fills the
// 60-word round-key RAM at one word per cycle (44, 52 or 60 words); reset also
// expands the all-zero 128-bit key. Input beats are held off until expansion
// completes. Command LOAD sets the chain value and gives no output beat.
// ENCRYPT and DECRYPT pass through the fetch, round and done states before the
// output beat: one round per cycle, paced by the round-key RAM, whose four
// words per round are read as one registered 128-bit row.
// The output register frees the engine: the next input beat can be taken at the
// same edge as the output beat. A finished block waits in the last stage while
// the output register is full.
module aes_cbc_block_cipher #(
    parameter int RK_DEPTH = aes_cbc_pkg::RK_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write channel.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // [63:0] block_high, [127:64] block_low
    input  logic [1:0]   s_axis_tuser,  // command
    // Output stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // [63:0] result_high, [127:64] result_low
);
    localparam int ROWS = RK_DEPTH / 4;
    localparam int RAW  = $clog2(ROWS);

    logic [1:0]   r_mode;
    logic [255:0] r_key;
    logic         r_kick;
    logic [127:0] r_chain, n_chain;
    logic [127:0] r_st, n_st;
    logic [127:0] r_blk, n_blk;
    logic         r_dec, n_dec;
    logic [3:0]   r_rnd, n_rnd;
    logic [3:0]   r_nr;
    logic [127:0] r_res, n_res;
    logic         r_ovld, n_ovld;
    aes_cbc_pkg::t_state r_state, n_state;

    aes_cbc_pkg::t_rk_wr   w_wr;
    aes_cbc_pkg::t_ks_stat w_ks;
    logic [127:0] w_rk;
    logic [RAW-1:0] w_raddr;
    logic [127:0] w_in;
    logic         w_acc;
    logic         w_ofree;
    aes_cbc_pkg::t_cmd w_cmd;

    assign w_in  = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign w_cmd = aes_cbc_pkg::t_cmd'(s_axis_tuser);
    assign o_cfg_ready = 1'b1;

    // Hold key registers; kick the scheduler on every write to a known register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_key  <= '0;
            r_kick <= 1'b1;
            r_nr   <= 4'd10;
        end else begin
            r_kick <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    aes_cbc_pkg::REG_KEY_SIZE: begin
                        r_mode <= i_cfg_data[1:0];
                        r_nr <= (i_cfg_data[1:0] == 2'd0) ? 4'd10 :
                                (i_cfg_data[1:0] == 2'd1) ? 4'd12 : 4'd14;
                        r_kick <= 1'b1;
                    end
                    aes_cbc_pkg::REG_KEY_A: begin
                        r_key[255:192] <= i_cfg_data;
                        r_kick <= 1'b1;
                    end
                    aes_cbc_pkg::REG_KEY_B: begin
                        r_key[191:128] <= i_cfg_data;
                        r_kick <= 1'b1;
                    end
                    aes_cbc_pkg::REG_KEY_C: begin
                        r_key[127:64] <= i_cfg_data;
                        r_kick <= 1'b1;
                    end
                    aes_cbc_pkg::REG_KEY_D: begin
                        r_key[63:0] <= i_cfg_data;
                        r_kick <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    aes_cbc_keysched u_ks (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (r_kick),
        .i_key_size_mode (r_mode),
        .i_key           (r_key),
        .o_wr            (w_wr),
        .o_stat          (w_ks)
    );

    // Round keys are stored as 32-bit words in four banks: word i lands in
    // bank i%4 at row i/4, so a round's four words are read together.
    for (genvar g = 0; g < 4; g++) begin : g_bank
        aes_cbc_ram #(
            .WIDTH (aes_cbc_pkg::RK_WIDTH),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_wr.en && (w_wr.addr[1:0] == 2'(g))),
            .i_waddr (RAW'(w_wr.addr >> 2)),
            .i_wdata (w_wr.data),
            .i_raddr (w_raddr),
            .o_rdata (w_rk[127-32*g -: 32])
        );
    end

    // The output register can take a finished block this cycle.
    assign w_ofree = !r_ovld || m_axis_tready;

    assign s_axis_tready = (r_state == aes_cbc_pkg::ST_IDLE) && !w_ks.busy && !r_kick;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // Row to fetch next: the round after the current one, mirrored for decrypt.
    // On the last round hold the address, the row is not used.
    always_comb begin
        logic [3:0] k;
        k = r_rnd;
        if (r_state == aes_cbc_pkg::ST_ROUND && r_rnd != r_nr) k = r_rnd + 4'd1;
        if (r_state == aes_cbc_pkg::ST_IDLE) begin
            w_raddr = (w_cmd == aes_cbc_pkg::CMD_DECRYPT) ? RAW'(r_nr) : '0;
        end else begin
            w_raddr = r_dec ? RAW'(r_nr - k) : RAW'(k);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aes_cbc_pkg::ST_IDLE: begin
                if (w_acc && (w_cmd == aes_cbc_pkg::CMD_ENCRYPT
                              || w_cmd == aes_cbc_pkg::CMD_DECRYPT)) begin
                    n_state = aes_cbc_pkg::ST_FETCH;
                end
            end
            aes_cbc_pkg::ST_FETCH:  n_state = aes_cbc_pkg::ST_ROUND;
            aes_cbc_pkg::ST_ROUND: begin
                if (r_rnd == r_nr) n_state = aes_cbc_pkg::ST_DONE;
            end
            aes_cbc_pkg::ST_DONE: begin
                if (w_ofree) n_state = aes_cbc_pkg::ST_IDLE;
            end
            default:                n_state = aes_cbc_pkg::ST_IDLE;
        endcase
    end

    // Datapath: key add from the row read last cycle, then one round.
    always_comb begin
        logic [127:0] x;
        n_chain = r_chain;
        n_st    = r_st;
        n_blk   = r_blk;
        n_dec   = r_dec;
        n_rnd   = r_rnd;
        n_res   = r_res;
        n_ovld  = r_ovld && !m_axis_tready;
        x       = r_st ^ w_rk;
        unique case (r_state)
            aes_cbc_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_blk = w_in;
                    n_dec = (w_cmd == aes_cbc_pkg::CMD_DECRYPT);
                    n_st  = (w_cmd == aes_cbc_pkg::CMD_ENCRYPT) ? (w_in ^ r_chain) : w_in;
                    n_rnd = 4'd1;
                    if (w_cmd == aes_cbc_pkg::CMD_LOAD) n_chain = w_in;
                end
            end
            aes_cbc_pkg::ST_FETCH: begin
                // Initial key add; row 0 (Nr if decrypting) is on the read port.
                if (r_dec) n_st = aes_cbc_pkg::inv_sub_shift(x);
                else       n_st = aes_cbc_pkg::enc_round(x, r_nr != 4'd1);
            end
            aes_cbc_pkg::ST_ROUND: begin
                n_rnd = r_rnd + 4'd1;
                if (r_rnd == r_nr) begin
                    n_st = x;
                end else if (r_dec) begin
                    n_st = aes_cbc_pkg::inv_sub_shift(aes_cbc_pkg::inv_mix(x));
                end else begin
                    n_st = aes_cbc_pkg::enc_round(x, r_rnd + 4'd1 != r_nr);
                end
            end
            aes_cbc_pkg::ST_DONE: begin
                // Hold the finished block here while the output register is full.
                if (w_ofree) begin
                    n_res   = r_dec ? (r_st ^ r_chain) : r_st;
                    n_chain = r_dec ? r_blk : r_st;
                    n_ovld  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aes_cbc_pkg::ST_IDLE;
            r_ovld  <= 1'b0;
            r_chain <= '0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_chain <= n_chain;
        end
        r_st  <= n_st;
        r_blk <= n_blk;
        r_dec <= n_dec;
        r_rnd <= n_rnd;
        r_res <= n_res;
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {r_res[63:0], r_res[127:64]};
endmodule

### rtl/core/aes_cbc_checker.sv
// Port-level checker for the AES-CBC block cipher, bound to the top level.
module aes_cbc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !$isunknown(m_axis_tdata))
        else $error("output beat carries unknown bits");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid
        && s_axis_tuser == aes_cbc_pkg::CMD_LOAD |=> !m_axis_tvalid)
        else $error("load produced an output beat");

    a_busy_after_cipher: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == aes_cbc_pkg::CMD_ENCRYPT
        || s_axis_tuser == aes_cbc_pkg::CMD_DECRYPT) |=> !s_axis_tready)
        else $error("new beat accepted during a block");
endmodule

bind aes_cbc_block_cipher aes_cbc_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### sim/tb_top.sv
// Self-checking testbench for the AES-CBC block cipher: keyed phases, random streams.
module tb_top;

    localparam int LIMIT = 600000;

    typedef struct {
        aes_cbc_pkg::t_cmd cmd;
        logic [63:0]       hi;
        logic [63:0]       lo;
    } t_blk_item;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_blk_out;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;  // [63:0] block_high, [127:64] block_low
    logic [1:0]   s_axis_tuser = '0;  // command
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;       // [63:0] result_high, [127:64] result_low

    aes_cbc_block_cipher u_top (.*);

    always #2 i_clk = ~i_clk;

    // Mirror of the cipher state: key registers, schedule and chain.
    logic [1:0]  mdl_key_mode;
    logic [63:0] mdl_key [4];
    logic [31:0] mdl_sched [60];
    int          mdl_rounds;
    logic [63:0] mdl_chain_hi, mdl_chain_lo;

    t_blk_item pending_blocks [$];
    t_blk_out  cipher_expected [$];

    int          cyc = 0;
    int          errors = 0;
    int          beats_taken = 0;
    int          beats_seen = 0;
    logic        hold_sink = 1'b0;
    logic        calm = 1'b0;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {aes_cbc_pkg::sbox(w[31:24]), aes_cbc_pkg::sbox(w[23:16]),
                aes_cbc_pkg::sbox(w[15:8]), aes_cbc_pkg::sbox(w[7:0])};
    endfunction

    // Rebuild the round-key schedule from the key registers.
    task automatic rebuild_schedule();
        int mode, nk, total;
        logic [31:0] t;
        logic [7:0] rc [10];
        rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
        mode = (mdl_key_mode == 2'd3) ? 2 : int'(mdl_key_mode);
        nk = 4 + 2 * mode;
        mdl_rounds = 10 + 2 * mode;
        total = 4 * (mdl_rounds + 1);
        for (int i = 0; i < nk; i++)
            mdl_sched[i] = (i % 2) ? mdl_key[i / 2][31:0] : mdl_key[i / 2][63:32];
        for (int i = nk; i < total; i++) begin
            t = mdl_sched[i - 1];
            if (i % nk == 0)
                t = subst_word({t[23:0], t[31:24]}) ^ {rc[(i / nk - 1) % 10], 24'h0};
            else if (nk > 6 && i % nk == 4)
                t = subst_word(t);
            mdl_sched[i] = mdl_sched[i - nk] ^ t;
        end
    endtask

    function automatic void add_key(ref logic [7:0] s [16], input int rnd);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[4*c+r] ^= mdl_sched[rnd*4+c][31-8*r -: 8];
    endfunction

    function automatic logic [127:0] fwd_cipher(input logic [127:0] x);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) s[i] = x[127-8*i -: 8];
        add_key(s, 0);
        for (int rnd = 1; rnd <= mdl_rounds; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[4*c+r] = aes_cbc_pkg::sbox(s[4*((c+r)%4)+r]);
            for (int c = 0; c < 4; c++) begin
                if (rnd < mdl_rounds) begin
                    s[4*c]   = gf_mul(t[4*c], 8'h02) ^ gf_mul(t[4*c+1], 8'h03)
                               ^ t[4*c+2] ^ t[4*c+3];
                    s[4*c+1] = t[4*c] ^ gf_mul(t[4*c+1], 8'h02)
                               ^ gf_mul(t[4*c+2], 8'h03) ^ t[4*c+3];
                    s[4*c+2] = t[4*c] ^ t[4*c+1] ^ gf_mul(t[4*c+2], 8'h02)
                               ^ gf_mul(t[4*c+3], 8'h03);
                    s[4*c+3] = gf_mul(t[4*c], 8'h03) ^ t[4*c+1] ^ t[4*c+2]
                               ^ gf_mul(t[4*c+3], 8'h02);
                end else begin
                    for (int r = 0; r < 4; r++) s[4*c+r] = t[4*c+r];
                end
            end
            add_key(s, rnd);
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
        return o;
    endfunction

    function automatic logic [127:0] inv_cipher(input logic [127:0] x);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) s[i] = x[127-8*i -: 8];
        add_key(s, mdl_rounds);
        for (int rnd = mdl_rounds - 1; rnd >= 0; rnd--) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[4*((c+r)%4)+r] = aes_cbc_pkg::inv_sbox(s[4*c+r]);
            s = t;
            add_key(s, rnd);
            if (rnd > 0) begin
                t = s;
                for (int c = 0; c < 4; c++) begin
                    s[4*c]   = gf_mul(t[4*c], 8'h0e) ^ gf_mul(t[4*c+1], 8'h0b)
                               ^ gf_mul(t[4*c+2], 8'h0d) ^ gf_mul(t[4*c+3], 8'h09);
                    s[4*c+1] = gf_mul(t[4*c], 8'h09) ^ gf_mul(t[4*c+1], 8'h0e)
                               ^ gf_mul(t[4*c+2], 8'h0b) ^ gf_mul(t[4*c+3], 8'h0d);
                    s[4*c+2] = gf_mul(t[4*c], 8'h0d) ^ gf_mul(t[4*c+1], 8'h09)
                               ^ gf_mul(t[4*c+2], 8'h0e) ^ gf_mul(t[4*c+3], 8'h0b);
                    s[4*c+3] = gf_mul(t[4*c], 8'h0b) ^ gf_mul(t[4*c+1], 8'h0d)
                               ^ gf_mul(t[4*c+2], 8'h09) ^ gf_mul(t[4*c+3], 8'h0e);
                end
            end
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
        return o;
    endfunction

    // Advance the chain for one accepted block and queue its result, if any.
    task automatic predict_block(input aes_cbc_pkg::t_cmd cmd, input logic [63:0] hi,
                                 input logic [63:0] lo);
        logic [127:0] r;
        t_blk_out e;
        case (cmd)
            aes_cbc_pkg::CMD_LOAD: begin
                mdl_chain_hi = hi;
                mdl_chain_lo = lo;
            end
            aes_cbc_pkg::CMD_ENCRYPT: begin
                r = fwd_cipher({hi ^ mdl_chain_hi, lo ^ mdl_chain_lo});
                e.hi = r[127:64];
                e.lo = r[63:0];
                mdl_chain_hi = e.hi;
                mdl_chain_lo = e.lo;
                cipher_expected = {cipher_expected, e};
            end
            aes_cbc_pkg::CMD_DECRYPT: begin
                r = inv_cipher({hi, lo});
                e.hi = r[127:64] ^ mdl_chain_hi;
                e.lo = r[63:0] ^ mdl_chain_lo;
                mdl_chain_hi = hi;
                mdl_chain_lo = lo;
                cipher_expected = {cipher_expected, e};
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [2:0] raw, input logic [63:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= raw;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        // Mirror the write; indexes past the key words are dropped.
        case (raw)
            aes_cbc_pkg::REG_KEY_SIZE: mdl_key_mode = v[1:0];
            aes_cbc_pkg::REG_KEY_A:    mdl_key[0] = v;
            aes_cbc_pkg::REG_KEY_B:    mdl_key[1] = v;
            aes_cbc_pkg::REG_KEY_C:    mdl_key[2] = v;
            aes_cbc_pkg::REG_KEY_D:    mdl_key[3] = v;
            default: ;
        endcase
        if (raw <= aes_cbc_pkg::REG_KEY_D) rebuild_schedule();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_blocks.size() != 0 || s_axis_tvalid || cipher_expected.size() != 0)
            @(posedge i_clk);
        // A trailing load may still be in flight; let it settle.
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_word();
        int k;
        k = $urandom_range(19);
        if (k == 0) return '0;
        if (k == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_block(input aes_cbc_pkg::t_cmd cmd, input logic [63:0] hi,
                               input logic [63:0] lo);
        t_blk_item it;
        it.cmd = cmd;
        it.hi = hi;
        it.lo = lo;
        pending_blocks = {pending_blocks, it};
    endtask

    // Driver: present the next block at the falling edge once the last one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || beats_taken != beats_seen)) begin
            beats_seen = beats_taken;
            if (pending_blocks.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
                t_blk_item it;
                it = pending_blocks.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= it.cmd;
                s_axis_tdata  <= {it.lo, it.hi};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver pacing: random idling, a quiet stretch, and the long hold-off.
    always @(negedge i_clk) begin
        if (hold_sink) m_axis_tready <= 1'b0;
        else m_axis_tready <= calm || ($urandom_range(99) >= 21);
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT) begin
            $display("[aes_cbc_block_cipher] ERROR");
            $finish;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            predict_block(aes_cbc_pkg::t_cmd'(s_axis_tuser), s_axis_tdata[63:0],
                          s_axis_tdata[127:64]);
            beats_taken = beats_taken + 1;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            if (cipher_expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output beat %h", m_axis_tdata);
            end else begin
                t_blk_out e;
                e = cipher_expected.pop_front();
                if (m_axis_tdata[63:0] !== e.hi || m_axis_tdata[127:64] !== e.lo) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp hi %h lo %h, got hi %h lo %h",
                                 e.hi, e.lo, m_axis_tdata[63:0], m_axis_tdata[127:64]);
                end
            end
        end
    end

    // Hold off the output for a long stretch while blocks keep coming, then a calm stretch.
    initial begin
        wait (cyc == 3000);
        hold_sink = 1'b1;
        repeat (500) @(posedge i_clk);
        hold_sink = 1'b0;
        wait (cyc == 9000);
        calm = 1'b1;
        repeat (5000) @(posedge i_clk);
        calm = 1'b0;
    end

    initial begin
        logic [1:0] modes [8];
        logic [63:0] kv;
        modes = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd2};
        mdl_key_mode = '0;
        for (int i = 0; i < 4; i++) mdl_key[i] = '0;
        mdl_chain_hi = '0;
        mdl_chain_lo = '0;
        rebuild_schedule();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero key after reset, extremes of every field and command.
        queue_block(aes_cbc_pkg::CMD_ENCRYPT, '0, '0);
        queue_block(aes_cbc_pkg::CMD_ENCRYPT, '1, '1);
        queue_block(aes_cbc_pkg::CMD_DECRYPT, '0, '0);
        queue_block(aes_cbc_pkg::CMD_DECRYPT, '1, '1);
        queue_block(aes_cbc_pkg::CMD_LOAD, '1, '1);
        queue_block(aes_cbc_pkg::CMD_ENCRYPT, '1, '0);
        queue_block(aes_cbc_pkg::CMD_DECRYPT, '0, '1);
        queue_block(aes_cbc_pkg::CMD_RSVD, '1, '1);
        queue_block(aes_cbc_pkg::CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_block(aes_cbc_pkg::CMD_LOAD, '0, '0);
        queue_block(aes_cbc_pkg::CMD_RSVD, '0, '0);
        queue_block(aes_cbc_pkg::CMD_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        queue_block(aes_cbc_pkg::CMD_LOAD, 64'h8000000000000000, 64'h0000000000000001);
        queue_block(aes_cbc_pkg::CMD_ENCRYPT, 64'h0000000000000001, 64'h8000000000000000);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            write_reg(aes_cbc_pkg::REG_KEY_SIZE, {62'($urandom()), modes[p]});
            for (int k = 0; k < 4; k++) begin
                kv = (p == 2) ? '1 : (p == 4) ? '0 : rand_word();
                write_reg(3'(aes_cbc_pkg::REG_KEY_A + k), kv);
            end
            // Writes past the register list must leave the key alone.
            write_reg(3'(5 + p % 3), rand_word());
            queue_block(aes_cbc_pkg::CMD_LOAD, rand_word(), rand_word());
            for (int n = 0; n < 180; n++) begin
                int pick;
                pick = $urandom_range(99);
                if (pick < 10)
                    queue_block(aes_cbc_pkg::CMD_LOAD, rand_word(), rand_word());
                else if (pick < 50)
                    queue_block(aes_cbc_pkg::CMD_ENCRYPT, rand_word(), rand_word());
                else if (pick < 93)
                    queue_block(aes_cbc_pkg::CMD_DECRYPT, rand_word(), rand_word());
                else
                    queue_block(aes_cbc_pkg::CMD_RSVD, rand_word(), rand_word());
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("[aes_cbc_block_cipher] OK");
        end else begin
            $display("[aes_cbc_block_cipher] ERROR");
        end
        $finish;
    end

endmodule
